@@ hw/rtl/rgbhsv_pkg.sv @@
package rgbhsv_pkg;

  localparam int unsigned NumCells = 12;
  localparam int unsigned QuotW    = NumCells;
  localparam int unsigned RemW     = 20;

  localparam logic [14:0] HueSector   = 15'd3840;
  localparam logic [14:0] HueFull     = 15'd23040;
  localparam logic [14:0] BaseRed     = 15'd0;
  localparam logic [14:0] BaseGreen   = 15'(2 * 3840);
  localparam logic [14:0] BaseBlue    = 15'(4 * 3840);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    logic        grey;
  } hsv_t;

  typedef struct packed {
    logic             valid;
    logic [RemW-1:0]  rem_hue;
    logic [RemW-1:0]  rem_sat;
    logic [7:0]       div_hue;
    logic [7:0]       div_sat;
    logic [QuotW-1:0] q_hue;
    logic [QuotW-1:0] q_sat;
    logic [14:0]      base;
    logic             neg;
    logic             grey;
    logic [7:0]       brightness;
  } cell_t;

endpackage

@@ hw/rtl/rgb_to_hsv_convert_core.sv @@
// RGB to HSV converter, one pixel per beat.
// Pipeline: one input stage, twelve divide cells and one output stage, each registered, between start and done_o.
// Throughput: one pixel per cycle; busy is tied low, as the divide cells are fully pipelined.
// Results appear on done_o for one cycle each; the receiver cannot stall.
// Reset (rst_ni, async, active low) clears all valid flags; data registers are not reset.
module rgb_to_hsv_convert_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rgbhsv_pkg::pixel_t  pixel_i,
  output logic                done_o,
  output rgbhsv_pkg::hsv_t    result_o
);
  import rgbhsv_pkg::*;

  cell_t chain [NumCells+1];

  assign busy = 1'b0;

  rgbhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start & ~busy),
    .pixel_i (pixel_i),
    .cell_o  (chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  rgbhsv_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cell_i   (chain[NumCells]),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

@@ hw/rtl/rgbhsv_front.sv @@
module rgbhsv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  rgbhsv_pkg::pixel_t  pixel_i,
  output rgbhsv_pkg::cell_t   cell_o
);
  import rgbhsv_pkg::*;

  logic [7:0]  mx, mn, delta, pa, pb, diff;
  logic [14:0] base;
  logic        neg;
  logic        valid_q;
  cell_t       data_d, data_q;

  always_comb begin
    mx = (pixel_i.red > pixel_i.green) ? pixel_i.red : pixel_i.green;
    mx = (mx > pixel_i.blue) ? mx : pixel_i.blue;
    mn = (pixel_i.red < pixel_i.green) ? pixel_i.red : pixel_i.green;
    mn = (mn < pixel_i.blue) ? mn : pixel_i.blue;
    delta = mx - mn;
    if (pixel_i.red >= mx) begin
      base = BaseRed;
      pa   = pixel_i.green;
      pb   = pixel_i.blue;
    end else if (pixel_i.green >= mx) begin
      base = BaseGreen;
      pa   = pixel_i.blue;
      pb   = pixel_i.red;
    end else begin
      base = BaseBlue;
      pa   = pixel_i.red;
      pb   = pixel_i.green;
    end
    neg  = pa < pb;
    diff = neg ? (pb - pa) : (pa - pb);

    data_d            = '0;
    data_d.valid      = 1'b1;
    data_d.rem_hue    = {diff, 12'b0} - {4'b0, diff, 8'b0};
    data_d.rem_sat    = {4'b0, delta, 8'b0} - {12'b0, delta};
    data_d.div_hue    = delta;
    data_d.div_sat    = mx;
    data_d.base       = base;
    data_d.neg        = neg;
    data_d.grey       = (delta == 8'd0);
    data_d.brightness = mx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

@@ hw/rtl/rgbhsv_cell.sv @@
module rgbhsv_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rgbhsv_pkg::cell_t  cell_i,
  output rgbhsv_pkg::cell_t  cell_o
);
  import rgbhsv_pkg::*;

  logic [RemW-1:0] dsh_hue, dsh_sat, rn_hue, rn_sat;
  logic            ge_hue, ge_sat;
  logic            valid_q;
  cell_t           data_d, data_q;

  always_comb begin
    dsh_hue = {1'b0, cell_i.div_hue, 11'b0};
    dsh_sat = {1'b0, cell_i.div_sat, 11'b0};
    ge_hue  = cell_i.rem_hue >= dsh_hue;
    ge_sat  = cell_i.rem_sat >= dsh_sat;
    rn_hue  = ge_hue ? (cell_i.rem_hue - dsh_hue) : cell_i.rem_hue;
    rn_sat  = ge_sat ? (cell_i.rem_sat - dsh_sat) : cell_i.rem_sat;

    data_d         = cell_i;
    data_d.rem_hue = {rn_hue[RemW-2:0], 1'b0};
    data_d.rem_sat = {rn_sat[RemW-2:0], 1'b0};
    data_d.q_hue   = {cell_i.q_hue[QuotW-2:0], ge_hue};
    data_d.q_sat   = {cell_i.q_sat[QuotW-2:0], ge_sat};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

@@ hw/rtl/rgbhsv_back.sv @@
module rgbhsv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rgbhsv_pkg::cell_t  cell_i,
  output logic               done_o,
  output rgbhsv_pkg::hsv_t   result_o
);
  import rgbhsv_pkg::*;

  logic [14:0] mag;
  logic        done_q;
  hsv_t        result_d, result_q;

  always_comb begin
    mag = {3'b0, cell_i.q_hue};
    result_d            = '0;
    result_d.brightness = cell_i.brightness;
    result_d.grey       = cell_i.grey;
    if (!cell_i.grey) begin
      if (!cell_i.neg) begin
        result_d.hue = cell_i.base + mag;
      end else if (mag > cell_i.base) begin
        result_d.hue = HueFull - mag + cell_i.base;
      end else begin
        result_d.hue = cell_i.base - mag;
      end
      result_d.saturation = cell_i.q_sat[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ hw/rtl/rgbhsv_checker.sv @@
module rgbhsv_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic                done_o,
  input  rgbhsv_pkg::hsv_t    result_o
);
  import rgbhsv_pkg::*;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##14 done_o)
    else $error("beat not delivered after 14 cycles");

  a_grey : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.grey) |-> (result_o.hue == 15'd0 && result_o.saturation == 8'd0))
    else $error("grey beat with nonzero hue or saturation");

  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.hue < HueFull))
    else $error("hue out of range");

  a_color : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.grey) |->
      (result_o.saturation != 8'd0 && result_o.brightness != 8'd0))
    else $error("colored beat with zero saturation or brightness");

endmodule

bind rgb_to_hsv_convert_core rgbhsv_checker u_rgbhsv_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

@@ tb/sv/tb_rgb_to_hsv_convert_core.sv @@
`timescale 1ns / 100ps

module tb_rgb_to_hsv_convert_core;
  import rgbhsv_pkg::*;

  localparam int unsigned LatencyCycles = 14;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned RandomPixels  = 520;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  pixel_t pixel_i;
  logic   done_o;
  hsv_t   result_o;

  hsv_t        hsv_expected_q[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned beats_sent;
  int unsigned results_checked;
  int unsigned grey_checked;
  int unsigned wrap_sent;

  rgb_to_hsv_convert_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .pixel_i  (pixel_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial clk_i = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic hsv_t predict_hsv(pixel_t px);
    hsv_t res;
    int   r;
    int   g;
    int   b;
    int   mx;
    int   mn;
    int   delta;
    int   base;
    int   pa;
    int   pb;
    int   h;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    delta = mx - mn;
    res.brightness = mx[7:0];
    if (delta == 0) begin
      res.hue = '0;
      res.saturation = '0;
      res.grey = 1'b1;
      return res;
    end
    if (r >= mx) begin
      base = int'(BaseRed);
      pa = g;
      pb = b;
    end else if (g >= mx) begin
      base = int'(BaseGreen);
      pa = b;
      pb = r;
    end else begin
      base = int'(BaseBlue);
      pa = r;
      pb = g;
    end
    if (pa >= pb) begin
      h = base + ((pa - pb) * int'(HueSector)) / delta;
    end else begin
      h = base - ((pb - pa) * int'(HueSector)) / delta;
    end
    if (h < 0) begin
      h = h + int'(HueFull);
    end
    res.hue = h[14:0];
    res.saturation = 8'((delta * 255) / mx);
    res.grey = 1'b0;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic idle_cycles(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_pixel(pixel_t px);
    hsv_t exp_res;
    start   <= 1'b1;
    pixel_i <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    exp_res = predict_hsv(px);
    hsv_expected_q.push_back(exp_res);
    beats_sent++;
    if (!exp_res.grey && px.red >= px.green && px.red >= px.blue && px.blue > px.green) begin
      wrap_sent++;
    end
  endtask

  task automatic wait_drained();
    while (hsv_expected_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    hsv_t exp_res;
    if (rst_ni && done_o) begin
      if (hsv_expected_q.size() == 0) begin
        $error("unexpected result beat: hue %0d sat %0d val %0d grey %0b",
               result_o.hue, result_o.saturation, result_o.brightness, result_o.grey);
        error_count++;
      end else begin
        exp_res = hsv_expected_q.pop_front();
        results_checked++;
        if (exp_res.grey) grey_checked++;
        if (result_o.hue !== exp_res.hue) begin
          $error("hue: expected %0d, actual %0d", exp_res.hue, result_o.hue);
          error_count++;
        end
        if (result_o.saturation !== exp_res.saturation) begin
          $error("saturation: expected %0d, actual %0d", exp_res.saturation,
                 result_o.saturation);
          error_count++;
        end
        if (result_o.brightness !== exp_res.brightness) begin
          $error("brightness: expected %0d, actual %0d", exp_res.brightness,
                 result_o.brightness);
          error_count++;
        end
        if (result_o.grey !== exp_res.grey) begin
          $error("grey: expected %0b, actual %0b", exp_res.grey, result_o.grey);
          error_count++;
        end
      end
    end
  end

  task automatic test_corner_pixels();
    pixel_t corners[$];
    corners = '{
      '{8'd0,   8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd255},
      '{8'd128, 8'd128, 8'd128},
      '{8'd1,   8'd1,   8'd1},
      '{8'd255, 8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd0},
      '{8'd0,   8'd0,   8'd255},
      '{8'd255, 8'd255, 8'd0},
      '{8'd0,   8'd255, 8'd255},
      '{8'd255, 8'd0,   8'd255},
      '{8'd255, 8'd0,   8'd1},
      '{8'd255, 8'd1,   8'd0},
      '{8'd1,   8'd0,   8'd0},
      '{8'd0,   8'd1,   8'd0},
      '{8'd0,   8'd0,   8'd1},
      '{8'd1,   8'd0,   8'd1},
      '{8'd255, 8'd254, 8'd254},
      '{8'd254, 8'd255, 8'd254},
      '{8'd254, 8'd254, 8'd255},
      '{8'd170, 8'd85,  8'd0},
      '{8'd0,   8'd85,  8'd170},
      '{8'd85,  8'd0,   8'd170},
      '{8'd200, 8'd200, 8'd100}
    };
    foreach (corners[i]) begin
      send_pixel(corners[i]);
      idle_cycles(i % 3);
    end
  endtask

  task automatic test_random_pixels(int unsigned count);
    pixel_t      px;
    int unsigned kind;
    int unsigned lvl;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      px.red   = 8'($urandom());
      px.green = 8'($urandom());
      px.blue  = 8'($urandom());
      lvl = $urandom_range(0, 255);
      if (kind < 45) begin
      end else if (kind < 60) begin
        px.red   = 8'(lvl);
        px.green = 8'(lvl + $urandom_range(0, 2) - 1);
        px.blue  = 8'(lvl + $urandom_range(0, 2) - 1);
      end else if (kind < 75) begin
        case ($urandom_range(0, 2))
          0: px.green = px.red;
          1: px.blue  = px.green;
          default: px.blue = px.red;
        endcase
      end else if (kind < 88) begin
        case ($urandom_range(0, 5))
          0: px.red   = 8'd0;
          1: px.green = 8'd0;
          2: px.blue  = 8'd0;
          3: px.red   = 8'd255;
          4: px.green = 8'd255;
          default: px.blue = 8'd255;
        endcase
      end else begin
        px.red   = 8'(lvl);
        px.green = 8'(lvl);
        px.blue  = 8'(lvl);
      end
      send_pixel(px);
      if ((i / 64) % 4 == 3) begin
        idle_cycles(0);
      end else begin
        idle_cycles(pick_gap());
      end
    end
  endtask

  task automatic test_drain_pause();
    pixel_t px;
    for (int unsigned i = 0; i < 8; i++) begin
      px.red   = 8'($urandom());
      px.green = 8'($urandom());
      px.blue  = 8'($urandom());
      send_pixel(px);
    end
    start <= 1'b0;
    wait_drained();
    for (int unsigned i = 0; i < 6; i++) begin
      px.red   = 8'($urandom());
      px.green = 8'($urandom());
      px.blue  = 8'($urandom());
      send_pixel(px);
      idle_cycles(i % 2);
    end
  endtask

  initial begin
    error_count     = 0;
    cycle_count     = 0;
    beats_sent      = 0;
    results_checked = 0;
    grey_checked    = 0;
    wrap_sent       = 0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    pixel_i         = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_drain_pause();
    test_random_pixels(RandomPixels);

    start <= 1'b0;
    wait_drained();
    repeat (LatencyCycles + 6) @(posedge clk_i);
    if (hsv_expected_q.size() != 0) begin
      $error("%0d expected results never arrived", hsv_expected_q.size());
      error_count += hsv_expected_q.size();
    end

    $display("Sent %0d pixels, checked %0d results (%0d grey, %0d red-sector wraps).",
             beats_sent, results_checked, grey_checked, wrap_sent);
    $display("Covered channel extremes, ties, near-grey pixels, drain pause and gaps.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
